[hdl/afsd_pkg.sv]
// Shared types, opcode pattern table and decode helpers for the AVR successor decoder.
`timescale 1ns / 1ps

package afsd_pkg;

	localparam int ADDR_W = 16;
	localparam int WORD_W = 16;

	// Decode class of one opcode word.
	typedef enum logic [3:0] {
		K_NEXT   = 4'd0,
		K_NEXT2  = 4'd1,
		K_NSTOP  = 4'd2,
		K_BRANCH = 4'd3,
		K_CALL   = 4'd4,
		K_SKIP   = 4'd5,
		K_UNSUP  = 4'd6,
		K_HALT   = 4'd7,
		K_JMP    = 4'd8,
		K_RCALL  = 4'd9,
		K_RETURN = 4'd10,
		K_RJMP   = 4'd11,
		K_UNDEF  = 4'd12
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNSUP = 2'd1,
		ST_UNDEF = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] match;
		kind_t             kind;
	} pattern_t;

	// Masks and matches of the two-word instructions.
	localparam logic [WORD_W-1:0] CALL_MASK  = 16'hFE0E;
	localparam logic [WORD_W-1:0] CALL_MATCH = 16'h940E;
	localparam logic [WORD_W-1:0] JMP_MATCH  = 16'h940C;
	localparam logic [WORD_W-1:0] LDS_MASK   = 16'hFE0F;
	localparam logic [WORD_W-1:0] LDS_MATCH  = 16'h9000;
	localparam logic [WORD_W-1:0] STS_MATCH  = 16'h9200;

	localparam int NUM_PATTERNS = 99;

	// Patterns in priority order; the first one that matches decides the class.
	localparam pattern_t PATTERNS [NUM_PATTERNS] = '{
		'{16'hFC00,16'h1C00,K_NEXT},  '{16'hFC00,16'h0C00,K_NEXT},  '{16'hFF00,16'h9600,K_NEXT},
		'{16'hFC00,16'h2000,K_NEXT},  '{16'hF000,16'h7000,K_NEXT},  '{16'hFE0F,16'h9405,K_NEXT},
		'{16'hFF8F,16'h9488,K_NEXT},  '{16'hFE08,16'hF800,K_NEXT},  '{16'hFC00,16'hF400,K_BRANCH},
		'{16'hFC00,16'hF000,K_BRANCH},'{16'hFF8F,16'h9408,K_NEXT},  '{16'hFE08,16'hFA00,K_NEXT},
		'{16'hFE0E,16'h940E,K_CALL},  '{16'hFF00,16'h9800,K_NEXT},  '{16'hFE0F,16'h9400,K_NEXT},
		'{16'hFC00,16'h1400,K_NEXT},  '{16'hFC00,16'h0400,K_NEXT},  '{16'hF000,16'h3000,K_NEXT},
		'{16'hFC00,16'h1000,K_SKIP},  '{16'hFE0F,16'h940A,K_NEXT},  '{16'hFF0F,16'h940B,K_UNSUP},
		'{16'hFFFF,16'h9519,K_UNSUP}, '{16'hFFFF,16'h9419,K_UNSUP}, '{16'hFFFF,16'h95D8,K_UNSUP},
		'{16'hFE0F,16'h9006,K_UNSUP}, '{16'hFE0F,16'h9007,K_UNSUP}, '{16'hFC00,16'h2400,K_NEXT},
		'{16'hFF88,16'h0308,K_NEXT},  '{16'hFF88,16'h0380,K_NEXT},  '{16'hFF88,16'h0388,K_NEXT},
		'{16'hFFFF,16'h9509,K_NEXT},  '{16'hFFFF,16'h9409,K_HALT},  '{16'hF800,16'hB000,K_NEXT},
		'{16'hFE0F,16'h9403,K_NEXT},  '{16'hFE0E,16'h940C,K_JMP},   '{16'hFE0F,16'h9206,K_NEXT},
		'{16'hFE0F,16'h9205,K_NEXT},  '{16'hFE0F,16'h9207,K_NEXT},  '{16'hFE0F,16'h900C,K_NEXT},
		'{16'hFE0F,16'h900D,K_NEXT},  '{16'hFE0F,16'h900E,K_NEXT},  '{16'hFE0F,16'h8008,K_NEXT},
		'{16'hFE0F,16'h9009,K_NEXT},  '{16'hFE0F,16'h900A,K_NEXT},  '{16'hFE0F,16'h8000,K_NEXT},
		'{16'hFE0F,16'h9001,K_NEXT},  '{16'hFE0F,16'h9002,K_NEXT},  '{16'hF000,16'hE000,K_NEXT},
		'{16'hFE0F,16'h9000,K_NEXT2}, '{16'hF800,16'hA000,K_NEXT},  '{16'hFFFF,16'h95C8,K_NEXT},
		'{16'hFE0F,16'h9004,K_NEXT},  '{16'hFE0F,16'h9005,K_NEXT},  '{16'hFE0F,16'h9406,K_NEXT},
		'{16'hFC00,16'h2C00,K_NEXT},  '{16'hFF00,16'h0100,K_NEXT},  '{16'hFC00,16'h9C00,K_NSTOP},
		'{16'hFF00,16'h0200,K_NSTOP}, '{16'hFF88,16'h0300,K_NSTOP}, '{16'hFE0F,16'h9401,K_NEXT},
		'{16'hFFFF,16'h0000,K_NEXT},  '{16'hFC00,16'h2800,K_NEXT},  '{16'hF000,16'h6000,K_NEXT},
		'{16'hF800,16'hB800,K_NEXT},  '{16'hFE0F,16'h900F,K_NEXT},  '{16'hFE0F,16'h920F,K_NEXT},
		'{16'hF000,16'hD000,K_RCALL}, '{16'hFFFF,16'h9508,K_RETURN},'{16'hFFFF,16'h9518,K_RETURN},
		'{16'hF000,16'hC000,K_RJMP},  '{16'hFE0F,16'h9407,K_NEXT},  '{16'hFC00,16'h0800,K_NEXT},
		'{16'hF000,16'h4000,K_NEXT},  '{16'hFF00,16'h9A00,K_NEXT},  '{16'hFF00,16'h9900,K_SKIP},
		'{16'hFF00,16'h9B00,K_SKIP},  '{16'hFF00,16'h9700,K_NEXT},  '{16'hFE08,16'hFC00,K_SKIP},
		'{16'hFE08,16'hFE00,K_SKIP},  '{16'hFFFF,16'h9588,K_NSTOP}, '{16'hFFFF,16'h95E8,K_NSTOP},
		'{16'hFFFF,16'h95F8,K_NSTOP}, '{16'hFE0F,16'h920C,K_NEXT},  '{16'hFE0F,16'h920D,K_NEXT},
		'{16'hFE0F,16'h920E,K_NEXT},  '{16'hFE0F,16'h8208,K_NEXT},  '{16'hFE0F,16'h9209,K_NEXT},
		'{16'hFE0F,16'h920A,K_NEXT},  '{16'hFE0F,16'h8200,K_NEXT},  '{16'hFE0F,16'h9201,K_NEXT},
		'{16'hFE0F,16'h9202,K_NEXT},  '{16'hFE0F,16'h9200,K_NEXT2}, '{16'hF800,16'hA800,K_NEXT},
		'{16'hFC00,16'h1800,K_NEXT},  '{16'hF000,16'h5000,K_NEXT},  '{16'hFE0F,16'h9402,K_NEXT},
		'{16'hFFFF,16'h95A8,K_NEXT},  '{16'hFE0F,16'h9204,K_NEXT},  '{16'hFFFF,16'h9598,K_HALT}
	};

	// First-match priority decode: scanning from the back lets earlier entries win.
	function automatic kind_t classify(input logic [WORD_W-1:0] inst);
		kind_t k;
		k = K_UNDEF;
		for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
			if ((inst & PATTERNS[i].mask) == PATTERNS[i].match) begin
				k = PATTERNS[i].kind;
			end
		end
		return k;
	endfunction

	// True when the word opens a 32-bit instruction (CALL, JMP, LDS, STS).
	function automatic logic two_word(input logic [WORD_W-1:0] w);
		return ((w & CALL_MASK) == CALL_MATCH) || ((w & CALL_MASK) == JMP_MATCH) ||
		       ((w & LDS_MASK) == LDS_MATCH) || ((w & LDS_MASK) == STS_MATCH);
	endfunction

endpackage

[hdl/avr_flow_successor_decoder_unit.sv]
// Top level of the AVR control-flow successor decoder, a three-stage pipeline.
`timescale 1ns / 1ps

// The block decodes one AVR program word per cycle and reports where control can
// go next: a branch, call, jump or skip target and the sequential fall-through.
// A word is handed in by raising start with word_address, instruction_word and
// following_word (the program word at address plus one). The word is taken at
// every rising edge where start is high and busy is low; busy stays low, so a
// new word may be issued in every cycle.
// Results leave after passing the register stages: done is high for exactly
// one cycle while the result ports hold that word's successors, flow_stop and
// decode_status. Words come out in the order they went in, one per cycle at
// full rate. Its three register stages are opcode class, address arithmetic,
// then range check into the output registers. The receiver cannot stall the
// block; it must take each result in its done cycle. Skip targets and
// fall-through addresses that run past the 16-bit space are reported as not
// valid with a zero address rather than wrapped; relative targets wrap.
// Reset (arst_n low) clears the stage valid bits at once, so any words in flight
// are dropped and done stays low until new words arrive; the block keeps no
// other state.
module avr_flow_successor_decoder_unit
	import afsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ADDR_W-1:0] word_address,
	input  logic [WORD_W-1:0] instruction_word,
	input  logic [WORD_W-1:0] following_word,
	output logic              done,
	output logic              target_valid,
	output logic [ADDR_W-1:0] target_address,
	output logic              fall_valid,
	output logic [ADDR_W-1:0] fall_address,
	output logic              flow_stop,
	output logic [1:0]        decode_status
);

	// The pipeline never holds off a word.
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// Stage 1: opcode class from the priority table, with the raw word fields.
	logic              valid_s1;
	kind_t             kind_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic [WORD_W-1:0] inst_s1;
	logic [WORD_W-1:0] nxt_s1;

	// Stage 2: candidate addresses one bit wider than the address space, so that an
	// overflow past the top can be seen in stage 3.
	logic              valid_s2;
	logic              tv_s2;
	logic [ADDR_W:0]   tgt_s2;
	logic              fv_s2;
	logic [ADDR_W:0]   fall_s2;
	logic              stop_s2;
	status_t           status_s2;

	// Stage 3: output registers.
	logic              valid_s3;
	logic              tv_s3;
	logic [ADDR_W-1:0] tgt_s3;
	logic              fv_s3;
	logic [ADDR_W-1:0] fall_s3;
	logic              stop_s3;
	status_t           status_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= classify(instruction_word);
			pc_s1   <= word_address;
			inst_s1 <= instruction_word;
			nxt_s1  <= following_word;
		end
	end

	// Stage 2 arithmetic. Relative targets wrap inside the address space; skip
	// and fall-through sums keep their carry.
	logic              tv_d;
	logic [ADDR_W:0]   tgt_d;
	logic              fv_d;
	logic [ADDR_W:0]   fall_d;
	logic              stop_d;
	status_t           status_d;
	logic [ADDR_W-1:0] branch_off;
	logic [ADDR_W-1:0] rel_off;
	logic [ADDR_W-1:0] branch_tgt;
	logic [ADDR_W-1:0] rel_tgt;
	logic [ADDR_W:0]   fall_one;
	logic [ADDR_W:0]   fall_two;
	logic [ADDR_W:0]   skip_tgt;

	assign branch_off = {{(ADDR_W-7){inst_s1[9]}}, inst_s1[9:3]};
	assign rel_off    = {{(ADDR_W-12){inst_s1[11]}}, inst_s1[11:0]};
	assign branch_tgt = pc_s1 + branch_off + ADDR_W'(1);
	assign rel_tgt    = pc_s1 + rel_off + ADDR_W'(1);
	assign fall_one   = {1'b0, pc_s1} + (ADDR_W+1)'(1);
	assign fall_two   = {1'b0, pc_s1} + (ADDR_W+1)'(2);
	assign skip_tgt   = fall_two + (ADDR_W+1)'(two_word(nxt_s1));

	always_comb begin
		tv_d     = 1'b0;
		tgt_d    = '0;
		fv_d     = 1'b0;
		fall_d   = '0;
		stop_d   = 1'b0;
		status_d = ST_OK;
		unique case (kind_s1)
			K_NEXT: begin
				fv_d   = 1'b1;
				fall_d = fall_one;
			end
			K_NEXT2: begin
				fv_d   = 1'b1;
				fall_d = fall_two;
			end
			K_NSTOP: begin
				fv_d   = 1'b1;
				fall_d = fall_one;
				stop_d = 1'b1;
			end
			K_BRANCH: begin
				fv_d   = 1'b1;
				fall_d = fall_one;
				tv_d   = 1'b1;
				tgt_d  = {1'b0, branch_tgt};
			end
			K_CALL: begin
				fv_d   = 1'b1;
				fall_d = fall_two;
				tv_d   = 1'b1;
				tgt_d  = {1'b0, nxt_s1};
			end
			K_SKIP: begin
				fv_d   = 1'b1;
				fall_d = fall_one;
				tv_d   = 1'b1;
				tgt_d  = skip_tgt;
			end
			K_RCALL: begin
				fv_d   = 1'b1;
				fall_d = fall_one;
				tv_d   = 1'b1;
				tgt_d  = {1'b0, rel_tgt};
			end
			K_RJMP: begin
				tv_d   = 1'b1;
				tgt_d  = {1'b0, rel_tgt};
				stop_d = 1'b1;
			end
			K_JMP: begin
				tv_d   = 1'b1;
				tgt_d  = {1'b0, nxt_s1};
				stop_d = 1'b1;
			end
			K_HALT: begin
				stop_d = 1'b1;
			end
			K_RETURN: begin
				stop_d = 1'b0;
			end
			K_UNSUP: begin
				stop_d   = 1'b1;
				status_d = ST_UNSUP;
			end
			default: begin
				stop_d   = 1'b1;
				status_d = ST_UNDEF;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tv_s2     <= tv_d;
			tgt_s2    <= tgt_d;
			fv_s2     <= fv_d;
			fall_s2   <= fall_d;
			stop_s2   <= stop_d;
			status_s2 <= status_d;
		end
	end

	// Stage 3: an address past the top of the space drops its valid bit, and an
	// address without a valid bit reads as zero.
	logic tgt_ok;
	logic fall_ok;
	assign tgt_ok  = tv_s2 & ~tgt_s2[ADDR_W];
	assign fall_ok = fv_s2 & ~fall_s2[ADDR_W];

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			tv_s3     <= tgt_ok;
			tgt_s3    <= tgt_ok ? tgt_s2[ADDR_W-1:0] : '0;
			fv_s3     <= fall_ok;
			fall_s3   <= fall_ok ? fall_s2[ADDR_W-1:0] : '0;
			stop_s3   <= stop_s2;
			status_s3 <= status_s2;
		end
	end

	assign done           = valid_s3;
	assign target_valid   = tv_s3;
	assign target_address = tgt_s3;
	assign fall_valid     = fv_s3;
	assign fall_address   = fall_s3;
	assign flow_stop      = stop_s3;
	assign decode_status  = status_s3;

`ifndef ASSERT_OFF
	// Every word taken comes out on done once it has passed the register stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted word did not complete after three cycles");

	// No result appears without a matching word taken earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without a matching accepted word");

	// A word that is not decoded has no successors and stops the flow.
	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && decode_status != ST_OK) |-> (flow_stop && !target_valid && !fall_valid))
		else $error("undecoded word reported successors");

	// Missing successors always read as address zero.
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((target_valid || target_address == '0) &&
		          (fall_valid || fall_address == '0)))
		else $error("address field set without its valid bit");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the AVR control-flow successor decoder.
`timescale 1ns / 1ps

// The bench sends program words into the decoder over the start/busy handshake
// and checks every done strobe against its own prediction of the successors.
// The prediction keeps a private copy of the opcode priority list, so a wrong
// entry in the design's table shows up as a mismatch. The stimulus starts with
// a short directed list: address extremes, every opcode class, wrapped relative
// targets, skips over 32-bit words and successors that fall off the top of the
// address space. After that come random words, most of them built from one
// opcode pattern with random operand bits, and the rest fully random.
module tb_top;
	import afsd_pkg::*;

	// One word as it goes onto the input ports.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] inst;
		logic [WORD_W-1:0] follow;
		logic              drain_first;
	} word_item_t;

	// Successors that one word is predicted to produce.
	typedef struct packed {
		logic              tv;
		logic [ADDR_W-1:0] taddr;
		logic              fv;
		logic [ADDR_W-1:0] faddr;
		logic              stop;
		status_t           status;
	} successor_t;

	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] match;
		kind_t             kind;
	} opcode_rule_t;

	localparam int NUM_RULES = 99;
	localparam int RANDOM_WORDS = 2000;

	// Opcode patterns in priority order. The first entry that matches a word
	// decides its class; anything that matches none of them is undefined.
	localparam opcode_rule_t DECODE_RULES [NUM_RULES] = '{
		'{16'hFC00,16'h1C00,K_NEXT},  '{16'hFC00,16'h0C00,K_NEXT},  '{16'hFF00,16'h9600,K_NEXT},
		'{16'hFC00,16'h2000,K_NEXT},  '{16'hF000,16'h7000,K_NEXT},  '{16'hFE0F,16'h9405,K_NEXT},
		'{16'hFF8F,16'h9488,K_NEXT},  '{16'hFE08,16'hF800,K_NEXT},  '{16'hFC00,16'hF400,K_BRANCH},
		'{16'hFC00,16'hF000,K_BRANCH},'{16'hFF8F,16'h9408,K_NEXT},  '{16'hFE08,16'hFA00,K_NEXT},
		'{16'hFE0E,16'h940E,K_CALL},  '{16'hFF00,16'h9800,K_NEXT},  '{16'hFE0F,16'h9400,K_NEXT},
		'{16'hFC00,16'h1400,K_NEXT},  '{16'hFC00,16'h0400,K_NEXT},  '{16'hF000,16'h3000,K_NEXT},
		'{16'hFC00,16'h1000,K_SKIP},  '{16'hFE0F,16'h940A,K_NEXT},  '{16'hFF0F,16'h940B,K_UNSUP},
		'{16'hFFFF,16'h9519,K_UNSUP}, '{16'hFFFF,16'h9419,K_UNSUP}, '{16'hFFFF,16'h95D8,K_UNSUP},
		'{16'hFE0F,16'h9006,K_UNSUP}, '{16'hFE0F,16'h9007,K_UNSUP}, '{16'hFC00,16'h2400,K_NEXT},
		'{16'hFF88,16'h0308,K_NEXT},  '{16'hFF88,16'h0380,K_NEXT},  '{16'hFF88,16'h0388,K_NEXT},
		'{16'hFFFF,16'h9509,K_NEXT},  '{16'hFFFF,16'h9409,K_HALT},  '{16'hF800,16'hB000,K_NEXT},
		'{16'hFE0F,16'h9403,K_NEXT},  '{16'hFE0E,16'h940C,K_JMP},   '{16'hFE0F,16'h9206,K_NEXT},
		'{16'hFE0F,16'h9205,K_NEXT},  '{16'hFE0F,16'h9207,K_NEXT},  '{16'hFE0F,16'h900C,K_NEXT},
		'{16'hFE0F,16'h900D,K_NEXT},  '{16'hFE0F,16'h900E,K_NEXT},  '{16'hFE0F,16'h8008,K_NEXT},
		'{16'hFE0F,16'h9009,K_NEXT},  '{16'hFE0F,16'h900A,K_NEXT},  '{16'hFE0F,16'h8000,K_NEXT},
		'{16'hFE0F,16'h9001,K_NEXT},  '{16'hFE0F,16'h9002,K_NEXT},  '{16'hF000,16'hE000,K_NEXT},
		'{16'hFE0F,16'h9000,K_NEXT2}, '{16'hF800,16'hA000,K_NEXT},  '{16'hFFFF,16'h95C8,K_NEXT},
		'{16'hFE0F,16'h9004,K_NEXT},  '{16'hFE0F,16'h9005,K_NEXT},  '{16'hFE0F,16'h9406,K_NEXT},
		'{16'hFC00,16'h2C00,K_NEXT},  '{16'hFF00,16'h0100,K_NEXT},  '{16'hFC00,16'h9C00,K_NSTOP},
		'{16'hFF00,16'h0200,K_NSTOP}, '{16'hFF88,16'h0300,K_NSTOP}, '{16'hFE0F,16'h9401,K_NEXT},
		'{16'hFFFF,16'h0000,K_NEXT},  '{16'hFC00,16'h2800,K_NEXT},  '{16'hF000,16'h6000,K_NEXT},
		'{16'hF800,16'hB800,K_NEXT},  '{16'hFE0F,16'h900F,K_NEXT},  '{16'hFE0F,16'h920F,K_NEXT},
		'{16'hF000,16'hD000,K_RCALL}, '{16'hFFFF,16'h9508,K_RETURN},'{16'hFFFF,16'h9518,K_RETURN},
		'{16'hF000,16'hC000,K_RJMP},  '{16'hFE0F,16'h9407,K_NEXT},  '{16'hFC00,16'h0800,K_NEXT},
		'{16'hF000,16'h4000,K_NEXT},  '{16'hFF00,16'h9A00,K_NEXT},  '{16'hFF00,16'h9900,K_SKIP},
		'{16'hFF00,16'h9B00,K_SKIP},  '{16'hFF00,16'h9700,K_NEXT},  '{16'hFE08,16'hFC00,K_SKIP},
		'{16'hFE08,16'hFE00,K_SKIP},  '{16'hFFFF,16'h9588,K_NSTOP}, '{16'hFFFF,16'h95E8,K_NSTOP},
		'{16'hFFFF,16'h95F8,K_NSTOP}, '{16'hFE0F,16'h920C,K_NEXT},  '{16'hFE0F,16'h920D,K_NEXT},
		'{16'hFE0F,16'h920E,K_NEXT},  '{16'hFE0F,16'h8208,K_NEXT},  '{16'hFE0F,16'h9209,K_NEXT},
		'{16'hFE0F,16'h920A,K_NEXT},  '{16'hFE0F,16'h8200,K_NEXT},  '{16'hFE0F,16'h9201,K_NEXT},
		'{16'hFE0F,16'h9202,K_NEXT},  '{16'hFE0F,16'h9200,K_NEXT2}, '{16'hF800,16'hA800,K_NEXT},
		'{16'hFC00,16'h1800,K_NEXT},  '{16'hF000,16'h5000,K_NEXT},  '{16'hFE0F,16'h9402,K_NEXT},
		'{16'hFFFF,16'h95A8,K_NEXT},  '{16'hFE0F,16'h9204,K_NEXT},  '{16'hFFFF,16'h9598,K_HALT}
	};

	// Clock, reset and the block's inputs. Every input holds a known value from
	// time zero on.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [ADDR_W-1:0] word_address = '0;
	logic [WORD_W-1:0] instruction_word = '0;
	logic [WORD_W-1:0] following_word = '0;

	logic              busy;
	logic              done;
	logic              target_valid;
	logic [ADDR_W-1:0] target_address;
	logic              fall_valid;
	logic [ADDR_W-1:0] fall_address;
	logic              flow_stop;
	logic [1:0]        decode_status;

	// Words still to be sent, and the successors of words taken by the block
	// whose result has not yet come back.
	word_item_t pending_words[$];
	successor_t expected_successors[$];

	int  mismatch_count = 0;
	int  words_accepted = 0;
	int  results_checked = 0;
	int  top_of_space_words = 0;
	int  total_words = 0;
	int  gap_left = 0;
	bit  classes_hit [16];

	avr_flow_successor_decoder_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.word_address     (word_address),
		.instruction_word (instruction_word),
		.following_word   (following_word),
		.done             (done),
		.target_valid     (target_valid),
		.target_address   (target_address),
		.fall_valid       (fall_valid),
		.fall_address     (fall_address),
		.flow_stop        (flow_stop),
		.decode_status    (decode_status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Opcode class by first match in the priority list.
	function automatic kind_t opcode_class(input logic [WORD_W-1:0] inst);
		kind_t k;
		bit    found;
		k = K_UNDEF;
		found = 1'b0;
		for (int i = 0; i < NUM_RULES; i++) begin
			if (!found && ((inst & DECODE_RULES[i].mask) == DECODE_RULES[i].match)) begin
				k = DECODE_RULES[i].kind;
				found = 1'b1;
			end
		end
		return k;
	endfunction

	// A skipped word that opens a 32-bit instruction makes the skip one word longer.
	function automatic bit opens_long_insn(input logic [WORD_W-1:0] w);
		return ((w & 16'hFE0E) == 16'h940E) || ((w & 16'hFE0E) == 16'h940C) ||
		       ((w & 16'hFE0F) == 16'h9000) || ((w & 16'hFE0F) == 16'h9200);
	endfunction

	// Successors of one word. Relative targets wrap within 16 bits; the
	// fall-through and the skip target are computed one bit wider so that a
	// result past the top of the space shows up as not valid instead of wrapping.
	function automatic successor_t predict_successors(input logic [ADDR_W-1:0] pc,
			input logic [WORD_W-1:0] inst, input logic [WORD_W-1:0] follow);
		successor_t      r;
		kind_t           k;
		logic [ADDR_W:0] fall_sum;
		logic [ADDR_W:0] skip_sum;
		logic [ADDR_W-1:0] rel;
		r = '0;
		r.status = ST_OK;
		fall_sum = '0;
		k = opcode_class(inst);
		case (k)
			K_NEXT, K_NSTOP, K_BRANCH, K_SKIP, K_RCALL: begin
				r.fv = 1'b1;
				fall_sum = {1'b0, pc} + 17'd1;
			end
			K_NEXT2, K_CALL: begin
				r.fv = 1'b1;
				fall_sum = {1'b0, pc} + 17'd2;
			end
			default: ;
		endcase
		case (k)
			K_NSTOP, K_HALT: r.stop = 1'b1;
			K_BRANCH: begin
				rel = {{9{inst[9]}}, inst[9:3]};
				r.tv = 1'b1;
				r.taddr = pc + rel + 16'd1;
			end
			K_RCALL, K_RJMP: begin
				rel = {{4{inst[11]}}, inst[11:0]};
				r.tv = 1'b1;
				r.taddr = pc + rel + 16'd1;
				r.stop = (k == K_RJMP);
			end
			K_CALL, K_JMP: begin
				r.tv = 1'b1;
				r.taddr = follow;
				r.stop = (k == K_JMP);
			end
			K_SKIP: begin
				skip_sum = {1'b0, pc} + 17'd2 + (opens_long_insn(follow) ? 17'd1 : 17'd0);
				r.tv = !skip_sum[ADDR_W];
				r.taddr = skip_sum[ADDR_W] ? '0 : skip_sum[ADDR_W-1:0];
			end
			K_UNSUP: begin
				r.stop = 1'b1;
				r.status = ST_UNSUP;
			end
			K_UNDEF: begin
				r.stop = 1'b1;
				r.status = ST_UNDEF;
			end
			default: ;
		endcase
		if (r.fv && fall_sum[ADDR_W]) begin
			r.fv = 1'b0;
		end
		r.faddr = r.fv ? fall_sum[ADDR_W-1:0] : '0;
		return r;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		mismatch_count++;
		$display("%0t: result %0d: %s got 0x%h, wanted 0x%h",
			$realtime, results_checked, what, got, want);
	endtask

	task automatic queue_word(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] inst,
			input logic [WORD_W-1:0] follow);
		pending_words.push_back('{addr, inst, follow, 1'b0});
	endtask

	// Driver. A word counts as taken at an edge where start is high and busy is
	// low; its successors are predicted from the very port values the block saw.
	// A word not yet taken stays on the ports. Otherwise the next word goes out,
	// unless an idle burst is running or the next word waits for the block to
	// empty. Idle bursts come in alternating stretches of 250 words and stop
	// altogether for the last 300.
	always @(posedge clk or negedge arst_n) begin : drive_words
		word_item_t nxt;
		bit         taken;
		bit         idling_on;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				expected_successors.push_back(
					predict_successors(word_address, instruction_word, following_word));
				classes_hit[opcode_class(instruction_word)] = 1'b1;
				if (word_address >= 16'hFFFD) begin
					top_of_space_words++;
				end
				words_accepted++;
			end
			idling_on = ((words_accepted / 250) % 2 == 0) &&
			            (words_accepted < total_words - 300);
			if (start && !taken) begin
				// The word is held until the block takes it.
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_words.size() == 0) begin
				start <= 1'b0;
			end else if (pending_words[0].drain_first && expected_successors.size() != 0) begin
				start <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				gap_left <= $urandom_range(0, 11);
				start <= 1'b0;
			end else begin
				nxt = pending_words.pop_front();
				word_address <= nxt.addr;
				instruction_word <= nxt.inst;
				following_word <= nxt.follow;
				start <= 1'b1;
			end
		end
	end

	// Monitor. A result is valid for the one cycle that ends at this edge and is
	// compared, field by field, with the oldest prediction still waiting.
	always @(posedge clk) begin : check_results
		successor_t want;
		if (arst_n && done) begin
			if (expected_successors.size() == 0) begin
				flag_mismatch("done with no word outstanding, target_address",
					target_address, '0);
			end else begin
				want = expected_successors.pop_front();
				if (target_valid !== want.tv)
					flag_mismatch("target_valid", ADDR_W'(target_valid), ADDR_W'(want.tv));
				if (target_address !== want.taddr)
					flag_mismatch("target_address", target_address, want.taddr);
				if (fall_valid !== want.fv)
					flag_mismatch("fall_valid", ADDR_W'(fall_valid), ADDR_W'(want.fv));
				if (fall_address !== want.faddr)
					flag_mismatch("fall_address", fall_address, want.faddr);
				if (flow_stop !== want.stop)
					flag_mismatch("flow_stop", ADDR_W'(flow_stop), ADDR_W'(want.stop));
				if (decode_status !== want.status)
					flag_mismatch("decode_status", ADDR_W'(decode_status),
						ADDR_W'(want.status));
			end
			results_checked++;
		end
	end

	// Fills the word list, releases reset, then waits for every word to be sent
	// and every result to come back before it rules on the run.
	initial begin : run_words
		word_item_t w;
		int         pick;
		int         classes;

		// Directed words: fall-through at both ends of the space, two-word
		// instructions whose pc+2 wraps past the top, CALL with operand bits set
		// in the opcode, branches and relative calls at their largest offsets in
		// both directions with wrap-around, a relative jump to itself, returns,
		// indirect jumps, skips over long and short words near the top,
		// stop-only words, an unsupported extended word and an undefined word.
		queue_word(16'h0000, 16'h0000, 16'h0000);
		queue_word(16'hFFFF, 16'h0000, 16'hFFFF);
		queue_word(16'hFFFE, 16'h9000, 16'h1234);
		queue_word(16'hFFFD, 16'h93F0, 16'hABCD);
		queue_word(16'hFFFE, 16'h940E, 16'h1234);
		queue_word(16'h0100, 16'h95FF, 16'hFFFF);
		queue_word(16'h0010, 16'h940C, 16'h0000);
		queue_word(16'h0000, 16'hF600, 16'h0000);
		queue_word(16'hFFFF, 16'hF1F8, 16'h5555);
		queue_word(16'hFFFF, 16'hD7FF, 16'h0000);
		queue_word(16'h0000, 16'hD800, 16'h0000);
		queue_word(16'h0005, 16'hCFFF, 16'h0000);
		queue_word(16'h8000, 16'h9508, 16'h9518);
		queue_word(16'h8001, 16'h9518, 16'h0000);
		queue_word(16'h1234, 16'h9409, 16'h0000);
		queue_word(16'h4321, 16'h9598, 16'h0000);
		queue_word(16'hFFFF, 16'h9509, 16'h0000);
		queue_word(16'hFFFD, 16'h1000, 16'h940C);
		queue_word(16'hFFFC, 16'h9900, 16'h9000);
		queue_word(16'hFFFE, 16'h9BFF, 16'h0000);
		queue_word(16'h0200, 16'hFE07, 16'h95FE);
		queue_word(16'h0300, 16'h9C00, 16'h0000);
		queue_word(16'h0400, 16'h95E8, 16'h0000);
		queue_word(16'h0500, 16'h940B, 16'h0000);
		queue_word(16'h0600, 16'h0001, 16'hFFFF);

		// Random words. Most use one opcode pattern with random operand bits, so
		// that every class, narrow ones like RET included, comes up often; the
		// rest are fully random. Skipped words open a 32-bit instruction fairly
		// often, and addresses crowd the top and bottom of the space at times.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 9) < 3) begin
				w.inst = WORD_W'($urandom_range(0, 16'hFFFF));
			end else begin
				pick = $urandom_range(0, NUM_RULES - 1);
				w.inst = DECODE_RULES[pick].match |
				         (WORD_W'($urandom) & ~DECODE_RULES[pick].mask);
			end
			case ($urandom_range(0, 9))
				0: w.follow = 16'h940C | (WORD_W'($urandom) & 16'h01F3);
				1: w.follow = 16'h9000 | (WORD_W'($urandom) & 16'h01F0);
				2: w.follow = 16'h9200 | (WORD_W'($urandom) & 16'h01F0);
				default: w.follow = WORD_W'($urandom_range(0, 16'hFFFF));
			endcase
			case ($urandom_range(0, 15))
				0, 1: w.addr = 16'hFFF0 + ADDR_W'($urandom_range(0, 15));
				2: w.addr = ADDR_W'($urandom_range(0, 15));
				default: w.addr = ADDR_W'($urandom_range(0, 16'hFFFF));
			endcase
			// Two words wait until the block has returned everything.
			w.drain_first = (n == 600 || n == 1300);
			pending_words.push_back(w);
		end
		total_words = pending_words.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_successors.size() != 0) begin
			@(posedge clk);
		end
		// Three register stages; waiting past them catches a stray done.
		repeat (8) @(posedge clk);

		classes = 0;
		for (int i = 0; i < 16; i++) begin
			classes += int'(classes_hit[i]);
		end
		$display("Checked %0d results for %0d words; %0d of 13 opcode classes decoded.",
			results_checked, words_accepted, classes);
		$display("%0d words sat in the top three addresses; %0d mismatches.",
			top_of_space_words, mismatch_count);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog, set far beyond the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d words pending and %0d results outstanding.",
			pending_words.size(), expected_successors.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
